// ===== rtl/pspv_pkg.sv =====
// package for the pitched sample playback voice
// holds shared types, widths and constants; no dependencies
package pspv_pkg;

   localparam int SAMPLE_BYTES_DEF = 65536;

   localparam int DIV_NUM_W = 40;
   localparam int DIV_DEN_W = 22;

   localparam int PITCH_Q_W = 38;
   localparam int RATE_Q_W  = 30;
   localparam int LEFT_W    = 23;

   localparam logic [LEFT_W-1:0] LEFT_MAX     = 23'd8388607;
   localparam logic [16:0]       OUT_RATE_RST = 17'd16000;
   localparam logic [21:0]       BASE_RST     = 22'd112640;
   localparam logic [13:0]       IN_RATE_HI   = 14'd16000;
   localparam logic [13:0]       IN_RATE_LO   = 14'd8000;
   localparam logic [9:0]        MS_PER_S     = 10'd1000;
   localparam logic [6:0]        VEL_FULL     = 7'd127;

   // reciprocals for the constant divides: x/1000 as (x>>3)*R125>>37, x/127 as x*R127>>30
   localparam logic [30:0]       RECIP_125    = 31'd1099511628;
   localparam logic [23:0]       RECIP_127    = 24'd8454661;

   typedef enum logic [1:0] {
      MODE_LOAD = 2'd0,
      MODE_NOTE = 2'd1,
      MODE_TICK = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      REG_OUTPUT_RATE = 3'd0,
      REG_SAMPLE_FMT  = 3'd1,
      REG_LOOP_EN     = 3'd2,
      REG_LEN_BYTES   = 3'd3,
      REG_BASE_FREQ   = 3'd4
   } reg_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LEN,
      S_LEN_Q,
      S_PITCH,
      S_RATE,
      S_MUL,
      S_MOD,
      S_RD_LO,
      S_RD_HI,
      S_DECODE,
      S_SCALE,
      S_SCALE_Q,
      S_PUSH
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
      logic [DIV_DEN_W-1:0] remainder;
   } div_rsp_type;

endpackage

// ===== rtl/pspv_store.sv =====
// byte-wide sample store, one write and one registered read port
// depends on pspv_pkg
module pspv_store import pspv_pkg::*; #(
   parameter int SAMPLE_BYTES = SAMPLE_BYTES_DEF,
   parameter int AW           = $clog2(SAMPLE_BYTES)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [SAMPLE_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pspv_div.sv =====
// shared restoring divider, one quotient bit per cycle
// depends on pspv_pkg
module pspv_div import pspv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int CNT_W = $clog2(DIV_NUM_W + 1);

   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   diff;
   logic                 ge;

   always_comb begin
      trial  = {rem_ff, num_ff[DIV_NUM_W-1]};
      ge     = trial >= {1'b0, den_ff};
      diff   = trial - {1'b0, den_ff};
      rem_in = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      num_in = {num_ff[DIV_NUM_W-2:0], ge};
      cnt_in = cnt_ff - CNT_W'(1);
      done_in = (cnt_ff == CNT_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (req.start) begin
         cnt_ff  <= CNT_W'(DIV_NUM_W);
         done_ff <= 1'b0;
      end else if (cnt_ff != '0) begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         num_ff <= req.dividend;
         rem_ff <= '0;
         den_ff <= req.divisor;
      end else if (cnt_ff != '0) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = num_ff;
   assign rsp.remainder = rem_ff;

endmodule

// ===== rtl/pitched_sample_playback_voice_unit.sv =====
// sampler voice top level: control sequencer, voice state and register port
// depends on pspv_pkg, pspv_store and pspv_div
//
// req channel: one word per item; mode selects a store byte load, a note
// start or an output tick. rsp channel: one word (sample and status) per
// tick, none for loads and note starts. csr: apb-style write/read of the
// five setup registers at byte addresses 0, 4, 8, 12 and 16.
// a load is written to the store as it is accepted. a note start gets the
// note length by reciprocal multiply, then takes two passes of the shared
// bit-serial divider (pitch ratio, rate ratio) and a shift-add multiply for
// the stride; a rest or invalid note ends after the note length step.
// a tick reads and decodes a sample, then scales it when velocity scaling
// applies; a silent tick skips these, and a divider pass comes first when
// the read position wraps. the store read port is registered, one byte per cycle.
// a finished tick waits in the output register; while the receiver stalls,
// the next finished tick holds the voice until that word is taken. reset
// clears the voice state and returns the registers to their reset values;
// the sample store keeps whatever it held and must be loaded before it is read.
module pitched_sample_playback_voice_unit import pspv_pkg::*; #(
   parameter int SAMPLE_BYTES = SAMPLE_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_mode,
   input  logic [15:0]         req_load_address,
   input  logic [7:0]          req_load_byte,
   input  logic [15:0]         req_note_duration_ms,
   input  logic [6:0]          req_note_velocity,
   input  logic [21:0]         req_target_freq_x256,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [15:0]  rsp_sample_value,
   output logic                rsp_status,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [4:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   localparam int AW   = $clog2(SAMPLE_BYTES);
   localparam int LA_W = (AW > 16) ? AW : 16;

   state_type state_ff, state_in;

   logic [16:0] out_rate_ff;
   logic [1:0]  fmt_ff;
   logic        loop_ff;
   logic [16:0] len_bytes_ff;
   logic [21:0] base_ff;

   logic [63:0]       pos_ff;
   logic [63:0]       step_ff;
   logic [LEFT_W-1:0] left_ff;
   logic [6:0]        vel_ff;
   logic              done_ff;

   logic [15:0]          dur_ff;
   logic [21:0]          tgt_ff;
   logic [PITCH_Q_W-1:0] pitch_ff;
   logic [RATE_Q_W-1:0]  rate_ff;
   logic [63:0]          acc_ff, acc_in;
   logic [4:0]           mcnt_ff;
   logic [7:0]           lo_ff;
   logic signed [15:0]   val_ff;
   logic signed [15:0]   res_val_ff;
   logic                 res_stat_ff;
   logic                 issued_ff;
   logic [32:0]          lprod_ff;
   logic [22:0]          mag_ff;
   logic                 neg_ff;

   logic               rsp_valid_ff;
   logic signed [15:0] rsp_value_ff;
   logic               rsp_status_ff;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;
   logic [LA_W-1:0] load_addr_ext;

   logic              accept;
   logic              csr_wr;
   logic [16:0]       count;
   logic [31:0]       idx;
   logic              idx_over;
   logic              invalid_note;
   logic              vel_scaled;
   logic              push_ok;
   logic              div_state;
   logic [32:0]       len_prod;
   logic [60:0]       len_full;
   logic [23:0]       len_q;
   logic [13:0]       in_rate;
   logic signed [15:0] decoded;
   logic signed [22:0] scaled_prod;
   logic [22:0]       scaled_mag;
   logic [46:0]       quot_full;
   logic [15:0]       scaled_q;
   logic [LEFT_W-1:0] len_sat;

   pspv_store #(.SAMPLE_BYTES(SAMPLE_BYTES), .AW(AW)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_load_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pspv_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      accept        = req_valid && req_ready;
      csr_wr        = csr_psel && csr_penable && csr_pwrite && csr_pready;
      count         = fmt_ff[1] ? {1'b0, len_bytes_ff[16:1]} : len_bytes_ff;
      idx           = pos_ff[63:32];
      idx_over      = idx >= {15'd0, count};
      invalid_note  = (tgt_ff == '0) || (base_ff == '0) || (count == '0) ||
                      (out_rate_ff == '0);
      vel_scaled    = (vel_ff != '0) && (vel_ff != VEL_FULL);
      push_ok       = !rsp_valid_ff || rsp_ready;
      len_prod      = 33'(dur_ff) * 33'(out_rate_ff);
      len_full      = 61'(lprod_ff[32:3]) * 61'(RECIP_125);
      len_q         = len_full[60:37];
      in_rate       = fmt_ff[0] ? IN_RATE_HI : IN_RATE_LO;
      decoded       = fmt_ff[1] ? $signed({rd_data, lo_ff}) : $signed({lo_ff, 8'h00});
      scaled_prod   = val_ff * $signed({1'b0, vel_ff});
      scaled_mag    = scaled_prod[22] ? 23'(-scaled_prod) : 23'(scaled_prod);
      quot_full     = 47'(mag_ff) * 47'(RECIP_127);
      scaled_q      = quot_full[45:30];
      len_sat       = len_q[23] ? LEFT_MAX : len_q[LEFT_W-1:0];
      acc_in        = {acc_ff[62:0], 1'b0} +
                      (rate_ff[RATE_Q_W-1] ? 64'(pitch_ff) : 64'd0);
      load_addr_ext = LA_W'(req_load_address);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (mode_type'(req_mode))
                  MODE_NOTE: state_in = S_LEN;
                  MODE_TICK: begin
                     if (left_ff == '0 || done_ff || step_ff == '0) begin
                        state_in = S_PUSH;
                     end else if (idx_over) begin
                        state_in = (loop_ff && count != '0) ? S_MOD : S_PUSH;
                     end else begin
                        state_in = S_RD_LO;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_LEN:     state_in = S_LEN_Q;
         S_LEN_Q:   state_in = invalid_note ? S_IDLE : S_PITCH;
         S_PITCH:   if (div_rsp.done) state_in = S_RATE;
         S_RATE:    if (div_rsp.done) state_in = S_MUL;
         S_MUL:     if (mcnt_ff == '0) state_in = S_IDLE;
         S_MOD:     if (div_rsp.done) state_in = S_RD_LO;
         S_RD_LO:   state_in = S_RD_HI;
         S_RD_HI:   state_in = S_DECODE;
         S_DECODE:  state_in = vel_scaled ? S_SCALE : S_PUSH;
         S_SCALE:   state_in = S_SCALE_Q;
         S_SCALE_Q: state_in = S_PUSH;
         S_PUSH:    if (push_ok) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = (state_ff == S_IDLE);
      wr_en     = accept && (mode_type'(req_mode) == MODE_LOAD);
      wr_addr   = load_addr_ext[AW-1:0];
      rd_addr   = fmt_ff[1] ? {idx[AW-2:0], 1'b0} : idx[AW-1:0];
      if (state_ff == S_RD_HI) begin
         rd_addr = {idx[AW-2:0], 1'b1};
      end
      div_state = (state_ff == S_PITCH) || (state_ff == S_RATE) || (state_ff == S_MOD);
      div_req.start    = div_state && !issued_ff;
      div_req.dividend = '0;
      div_req.divisor  = '0;
      case (state_ff)
         S_PITCH: begin
            div_req.dividend = DIV_NUM_W'({tgt_ff, 16'h0000});
            div_req.divisor  = base_ff;
         end
         S_RATE: begin
            div_req.dividend = DIV_NUM_W'({in_rate, 16'h0000});
            div_req.divisor  = DIV_DEN_W'(out_rate_ff);
         end
         S_MOD: begin
            div_req.dividend = DIV_NUM_W'(idx);
            div_req.divisor  = DIV_DEN_W'(count);
         end
         default: begin
            div_req.dividend = '0;
            div_req.divisor  = '0;
         end
      endcase
   end

   // control and voice state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         step_ff      <= '0;
         left_ff      <= '0;
         vel_ff       <= '0;
         done_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (div_rsp.done) begin
            issued_ff <= 1'b0;
         end else if (div_req.start) begin
            issued_ff <= 1'b1;
         end
         if (state_ff == S_PUSH && push_ok) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept && mode_type'(req_mode) == MODE_NOTE) begin
                  vel_ff  <= req_note_velocity;
                  pos_ff  <= '0;
                  done_ff <= 1'b0;
               end
               if (accept && mode_type'(req_mode) == MODE_TICK && left_ff != '0) begin
                  left_ff <= left_ff - LEFT_W'(1);
                  if (!done_ff && step_ff != '0 && idx_over &&
                      !(loop_ff && count != '0)) begin
                     done_ff <= 1'b1;
                  end
               end
            end
            S_LEN_Q: begin
               left_ff <= len_sat;
               if (invalid_note) begin
                  step_ff <= '0;
                  done_ff <= 1'b1;
               end
            end
            S_MUL: if (mcnt_ff == '0) step_ff <= acc_in;
            S_MOD: if (div_rsp.done) pos_ff <= {10'd0, div_rsp.remainder, pos_ff[31:0]};
            S_DECODE: pos_ff <= pos_ff + step_ff;
            default: ;
         endcase
      end
   end

   // operands and result words
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            dur_ff      <= req_note_duration_ms;
            tgt_ff      <= req_target_freq_x256;
            res_val_ff  <= '0;
            res_stat_ff <= (left_ff == '0);
         end
         S_LEN: lprod_ff <= len_prod;
         S_PITCH: if (div_rsp.done) pitch_ff <= div_rsp.quotient[PITCH_Q_W-1:0];
         S_RATE: begin
            if (div_rsp.done) begin
               rate_ff <= div_rsp.quotient[RATE_Q_W-1:0];
               acc_ff  <= '0;
               mcnt_ff <= 5'(RATE_Q_W - 1);
            end
         end
         S_MUL: begin
            acc_ff  <= acc_in;
            rate_ff <= {rate_ff[RATE_Q_W-2:0], 1'b0};
            mcnt_ff <= mcnt_ff - 5'd1;
         end
         S_RD_HI: lo_ff <= rd_data;
         S_DECODE: begin
            val_ff      <= decoded;
            res_val_ff  <= decoded;
            res_stat_ff <= 1'b0;
         end
         S_SCALE: begin
            mag_ff <= scaled_mag;
            neg_ff <= scaled_prod[22];
         end
         S_SCALE_Q: res_val_ff <= neg_ff ? $signed(-scaled_q) : $signed(scaled_q);
         default: ;
      endcase
      if (state_ff == S_PUSH && push_ok) begin
         rsp_value_ff  <= res_val_ff;
         rsp_status_ff <= res_stat_ff;
      end
   end

   // register port
   always_ff @(posedge clock) begin
      if (reset) begin
         out_rate_ff  <= OUT_RATE_RST;
         fmt_ff       <= '0;
         loop_ff      <= 1'b0;
         len_bytes_ff <= '0;
         base_ff      <= BASE_RST;
      end else if (csr_wr) begin
         case (reg_index_type'(csr_paddr[4:2]))
            REG_OUTPUT_RATE: out_rate_ff  <= csr_pwdata[16:0];
            REG_SAMPLE_FMT:  fmt_ff       <= csr_pwdata[1:0];
            REG_LOOP_EN:     loop_ff      <= csr_pwdata[0];
            REG_LEN_BYTES:   len_bytes_ff <= csr_pwdata[16:0];
            REG_BASE_FREQ:   base_ff      <= csr_pwdata[21:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index_type'(csr_paddr[4:2]))
         REG_OUTPUT_RATE: csr_prdata = 32'(out_rate_ff);
         REG_SAMPLE_FMT:  csr_prdata = 32'(fmt_ff);
         REG_LOOP_EN:     csr_prdata = 32'(loop_ff);
         REG_LEN_BYTES:   csr_prdata = 32'(len_bytes_ff);
         REG_BASE_FREQ:   csr_prdata = 32'(base_ff);
         default:         csr_prdata = '0;
      endcase
   end

   assign csr_pready       = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

// ===== verif/tb_top.sv =====
// testbench for the pitched sample playback voice unit
// scoreboard class predicts each tick word; depends on pspv_pkg and the rtl top level
`timescale 1ns / 100ps

module tb_top;
   import pspv_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int STORE_SIZE = 65536;
   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 250;

   typedef struct {
      logic [1:0]  mode;
      logic [15:0] addr;
      logic [7:0]  data;
      logic [15:0] dur;
      logic [6:0]  vel;
      logic [21:0] tgt;
   } voice_word_type;

   typedef struct {
      logic [15:0] sample;
      logic        status;
   } tick_word_type;

   class voice_scoreboard;
      bit [7:0] mem [STORE_SIZE];
      bit seen [STORE_SIZE];
      longint unsigned pos, step;
      int unsigned left;
      int unsigned vel;
      bit done;
      int unsigned rate = OUT_RATE_RST, fmt = 0, lp = 0, len = 0, base = BASE_RST;
      tick_word_type expected_ticks[$];
      int errors = 0;
      int ticks_seen = 0, notes_seen = 0, loads_seen = 0;

      function int unsigned count();
         return fmt[1] ? (len >> 1) : len;
      endfunction

      function void set_reg(reg_index_type r, int unsigned v);
         case (r)
            REG_OUTPUT_RATE: rate = v & 32'h1FFFF;
            REG_SAMPLE_FMT:  fmt  = v & 32'h3;
            REG_LOOP_EN:     lp   = v & 32'h1;
            REG_LEN_BYTES:   len  = v & 32'h1FFFF;
            default:         base = v & 32'h3FFFFF;
         endcase
      endfunction

      // byte addresses the next tick would read
      function void tick_reads(output int n, output int a0, output int a1);
         longint unsigned idx, p;
         int unsigned cnt;
         cnt = count();
         n = 0; a0 = 0; a1 = 0;
         if (left == 0 || done || step == 0) return;
         p = pos;
         idx = p >> 32;
         if (idx >= cnt) begin
            if (lp != 0 && cnt != 0) begin
               p = p % (longint'(cnt) << 32);
               idx = p >> 32;
            end else return;
         end
         if (fmt[1]) begin
            n = 2;
            a0 = int'((idx * 2) % STORE_SIZE);
            a1 = int'((idx * 2 + 1) % STORE_SIZE);
         end else begin
            n = 1; a0 = int'(idx % STORE_SIZE);
         end
      endfunction

      function int next_sample();
         longint unsigned idx;
         int unsigned cnt;
         int v;
         bit [15:0] u;
         cnt = count();
         if (done || step == 0) return 0;
         idx = pos >> 32;
         if (idx >= cnt) begin
            if (lp != 0 && cnt != 0) begin
               pos = pos % (longint'(cnt) << 32);
               idx = pos >> 32;
            end else begin
               done = 1;
               return 0;
            end
         end
         if (fmt[1]) begin
            u = {mem[(idx * 2 + 1) % STORE_SIZE], mem[(idx * 2) % STORE_SIZE]};
            v = int'(signed'(u));
         end else begin
            v = int'(signed'(mem[idx % STORE_SIZE])) * 256;
         end
         pos += step;
         if (vel > 0 && vel < VEL_FULL) v = (v * int'(vel)) / 127;
         return v;
      endfunction

      function void note_input(voice_word_type w);
         longint unsigned nlen, in_rate, pitch, rq, t;
         tick_word_type e;
         int v;
         case (w.mode)
            MODE_LOAD: begin
               mem[w.addr] = w.data;
               seen[w.addr] = 1;
               loads_seen++;
            end
            MODE_NOTE: begin
               notes_seen++;
               nlen = (longint'(w.dur) * rate) / MS_PER_S;
               left = (nlen > LEFT_MAX) ? 32'(LEFT_MAX) : 32'(nlen);
               vel = 32'(w.vel);
               pos = 0;
               done = 0;
               in_rate = fmt[0] ? 64'(IN_RATE_HI) : 64'(IN_RATE_LO);
               if (w.tgt == 0 || base == 0 || count() == 0 || rate == 0) begin
                  step = 0;
                  done = 1;
               end else begin
                  t = 64'(w.tgt);
                  pitch = (t << 16) / base;
                  rq = (in_rate << 16) / rate;
                  step = pitch * rq;
               end
            end
            MODE_TICK: begin
               ticks_seen++;
               if (left == 0) begin
                  e.sample = 0; e.status = 1;
               end else begin
                  v = next_sample();
                  left--;
                  e.sample = v[15:0]; e.status = 0;
               end
               expected_ticks.push_back(e);
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic [15:0] s, logic st);
         tick_word_type e;
         if (expected_ticks.size() == 0) begin
            $error("unexpected word: sample_value %0d status %0d", $signed(s), st);
            errors++;
            return;
         end
         e = expected_ticks.pop_front();
         if (s !== e.sample) begin
            $error("sample_value: expected %0d actual %0d", $signed(e.sample), $signed(s));
            errors++;
         end
         if (st !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, st);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_ready;
   logic [1:0] req_mode = 0;
   logic [15:0] req_load_address = 0;
   logic [7:0] req_load_byte = 0;
   logic [15:0] req_note_duration_ms = 0;
   logic [6:0] req_note_velocity = 0;
   logic [21:0] req_target_freq_x256 = 0;
   logic rsp_valid, rsp_ready = 0;
   logic signed [15:0] rsp_sample_value;
   logic rsp_status;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [4:0] csr_paddr = 0;
   logic [31:0] csr_pwdata = 0, csr_prdata;
   logic csr_pready;

   voice_scoreboard sb = new();
   int send_idle = 0, recv_idle = 0, hold_request = 0;
   int stall_count = 0;
   int items_sent = 0;

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   pitched_sample_playback_voice_unit i_dut (.*);

   always @(posedge clock) begin
      if (!reset && ((req_valid && req_ready) || (rsp_valid && rsp_ready))) stall_count <= 0;
      else stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // receiver: checks each word and picks next ready
   initial begin : receiver
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_sample_value, rsp_status);
         if (hold_request > 0) begin
            hold = hold_request;
            hold_request = 0;
         end
         if (hold > 0) begin
            hold--;
            rsp_ready <= 0;
         end else rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   task automatic req_idle();
      req_valid <= 0;
   endtask

   task automatic send_word(voice_word_type w);
      int n;
      if (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 0;
         n = $urandom_range(1, 4);
         repeat (n) @(posedge clock);
      end
      req_valid <= 1;
      req_mode <= w.mode;
      req_load_address <= w.addr;
      req_load_byte <= w.data;
      req_note_duration_ms <= w.dur;
      req_note_velocity <= w.vel;
      req_target_freq_x256 <= w.tgt;
      do @(posedge clock); while (!req_ready);
      sb.note_input(w);
      items_sent++;
   endtask

   task automatic send_load(int a, int d);
      voice_word_type w;
      w = '{MODE_LOAD, a[15:0], d[7:0], 16'($urandom), 7'($urandom), 22'($urandom)};
      send_word(w);
   endtask

   task automatic send_note(int dur, int vel, int tgt);
      voice_word_type w;
      w = '{MODE_NOTE, 16'($urandom), 8'($urandom), dur[15:0], vel[6:0], tgt[21:0]};
      send_word(w);
   endtask

   // fills any store byte the tick would read before sending it
   task automatic send_tick();
      voice_word_type w;
      int n, a0, a1;
      sb.tick_reads(n, a0, a1);
      if (n > 0 && !sb.seen[a0]) send_load(a0, $urandom_range(255));
      if (n > 1 && !sb.seen[a1]) send_load(a1, $urandom_range(255));
      w = '{MODE_TICK, 16'($urandom), 8'($urandom), 16'($urandom), 7'($urandom),
            22'($urandom)};
      send_word(w);
   endtask

   task automatic drain();
      req_idle();
      while (sb.expected_ticks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(reg_index_type r, int unsigned v);
      @(posedge clock);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= 5'(4 * r);
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      sb.set_reg(r, v);
   endtask

   task automatic setup(int unsigned rate, int unsigned fmt, int unsigned lp,
                        int unsigned len, int unsigned base);
      drain();
      csr_write(REG_OUTPUT_RATE, rate);
      csr_write(REG_SAMPLE_FMT, fmt);
      csr_write(REG_LOOP_EN, lp);
      csr_write(REG_LEN_BYTES, len);
      csr_write(REG_BASE_FREQ, base);
   endtask

   task automatic random_note();
      int dur, vel, tgt, k;
      dur = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(0, 30);
      k = $urandom_range(5);
      vel = (k == 0) ? 0 : (k == 1) ? 127 : $urandom_range(127);
      if ($urandom_range(9) < 6 && sb.base != 0) begin
         tgt = int'((longint'(sb.base) * $urandom_range(4, 64)) / 16);
         if (tgt > 22'h3FFFFF) tgt = 22'h3FFFFF;
      end else tgt = $urandom_range(22'h3FFFFF);
      if ($urandom_range(19) == 0) tgt = 0;
      send_note(dur, vel, tgt);
   endtask

   task automatic random_items(int n);
      int k, ticks, goal;
      goal = items_sent + n;
      while (items_sent < goal) begin
         k = $urandom_range(99);
         if (k < 70) begin
            random_note();
            ticks = $urandom_range(2, 20);
            repeat (ticks) send_tick();
         end else if (k < 85) begin
            send_tick();
         end else if (k < 96) begin
            send_load($urandom_range(65535), $urandom_range(255));
         end else begin
            send_word('{MODE_UNUSED, 16'($urandom), 8'($urandom), 16'($urandom),
                        7'($urandom), 22'($urandom)});
         end
      end
   endtask

   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 0;

      send_idle = 19; recv_idle = 52;
      setup(16000, 0, 0, 32, 112640);
      send_tick();
      send_word('{MODE_UNUSED, '1, '1, '1, '1, '1});
      send_load(0, 0);
      send_load(65535, 255);
      send_note(0, 64, 112640);
      send_tick();
      send_note(65535, 127, 112640);
      send_tick(); send_tick();
      send_note(20, 0, 22'h3FFFFF);
      send_tick(); send_tick();
      send_note(20, 1, 112640);
      send_tick(); send_tick();
      send_note(20, 126, 225280);
      send_tick(); send_tick();
      send_note(20, 100, 0);
      send_tick(); send_tick();
      random_items(150);

      setup(1000, 3, 1, 64, 4194303);
      random_items(60);
      hold_request = 400;
      repeat (30) send_tick();
      random_items(80);

      setup(96000, 2, 1, 65536, 112640);
      random_items(170);

      send_idle = 52; recv_idle = 19;
      setup(8000, 1, 0, 0, 112640);
      random_items(120);

      setup(44100, 3, 1, 7, 56320);
      random_items(80);
      drain();
      random_items(80);

      setup(22050, 0, 1, 1, 0);
      random_items(120);

      send_idle = 0; recv_idle = 0;
      setup(48000, 1, 1, 200, 112640);
      random_items(170);

      setup(96000, 2, 0, 65535, 225280);
      random_items(170);

      setup(1000, 0, 1, 48, 1);
      random_items(270);

      drain();
      $display("tb_top: %0d ticks, %0d note starts, %0d loads over nine register setups",
               sb.ticks_seen, sb.notes_seen, sb.loads_seen);
      $display("tb_top: both rates, both sample widths, looping and one-shot, %0d errors",
               sb.errors);
      if (sb.errors == 0 && sb.expected_ticks.size() == 0) $display("tb_top: PASS");
      else $display("tb_top: FAIL");
      $finish;
   end

endmodule

// ===== pitched_sample_playback_voice_unit.f =====
rtl/pspv_pkg.sv
rtl/pspv_store.sv
rtl/pspv_div.sv
rtl/pitched_sample_playback_voice_unit.sv
verif/tb_top.sv
